// File: rtl/core/rsq_pkg.sv
package rsq_pkg;

    // Field widths of the request and response beats.
    localparam int TAG_W  = 16;
    localparam int SIZE_W = 32;
    localparam int TIME_W = 32;
    localparam int OCC_W  = 5;
    localparam int SUM_W  = 40;

    // Action codes.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Service order codes.
    localparam logic MODE_STACK   = 1'b0;
    localparam logic MODE_LARGEST = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              action;
        logic [TAG_W-1:0]  request_tag;
        logic [SIZE_W-1:0] request_size;
        logic [TIME_W-1:0] time_now;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  out_tag;
        logic [SIZE_W-1:0] out_size;
        logic [TIME_W-1:0] latency;
        logic [OCC_W-1:0]  occupancy;
        logic [31:0]       served_total;
        logic [SUM_W-1:0]  latency_sum;
    } rsp_t;

    // One stored queue entry.
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] arrival;
    } entry_t;

endpackage

// File: rtl/core/request_scheduler_queue_top.sv
// Channel | Direction | Signals                        | Beat taken when
// cfg     | in        | cfg_wr_en, cfg_wr_data         | cfg_wr_en high
// req     | in        | req_valid, req_stall, req_data | req_valid and not req_stall
// rsp     | out       | rsp_valid, rsp_stall, rsp_data | rsp_valid and not rsp_stall
//
// A push, a rejected push or a pop on an empty queue goes through S_DONE to the result.
// A pop in largest-first mode scans every held entry, then moves down each entry above the
// picked slot; in stack mode it reads only the top entry. The single read port of the entry
// memory sets the pace, as the scan and the compaction each move one entry per cycle.
// Reset clears the count, the statistics and the mode; entry contents are not cleared.
// One request is in work at a time; the response register holds a result under rsp_stall.
module request_scheduler_queue_top
    import rsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_LAT   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Control registers.
    logic [2:0]       state_reg, state_next;
    logic             mode_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      served_reg, served_next;
    logic [SUM_W-1:0] lat_sum_reg, lat_sum_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             first_reg, first_next;

    // Payload registers.
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    entry_t            best_reg, best_next;
    req_t              item_reg, item_next;
    logic [1:0]        status_reg, status_next;
    logic [TIME_W-1:0] lat_reg, lat_next;
    rsp_t              rsp_reg, rsp_next;
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    // Entry memory ports.
    entry_t           mem [QUEUE_DEPTH];
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             req_accept;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic [SUM_W:0]   sum_wide;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign sum_wide = {1'b0, lat_sum_reg} + (SUM_W + 1)'(lat_reg);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        served_next    = served_reg;
        lat_sum_next   = lat_sum_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        first_next     = first_reg;
        ptr_next       = ptr_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        lat_next       = lat_reg;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = '{tag: req_data.request_tag, size: req_data.request_size,
                           arrival: req_data.time_now};

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    item_next   = req_data;
                    first_next  = 1'b1;
                    best_next   = '0;
                    lat_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    if (req_data.action == ACT_PUSH)
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ptr_next   = (mode_reg == MODE_LARGEST) ? '0 : cnt_m1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Read one entry per cycle and keep the best one seen so far.
                rd_en = (ptr_reg < count_reg);
                if (rd_en)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (first_reg || (rd_data_reg.size > best_reg.size))
                    begin
                        best_next     = rd_data_reg;
                        best_idx_next = rd_idx_reg;
                    end
                    first_next = 1'b0;
                    if (rd_idx_reg == last_idx)
                    begin
                        ptr_next   = CNT_W'(best_idx_next) + CNT_W'(1);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Move each entry above the picked slot down by one.
                rd_en = (ptr_reg < count_reg);
                if (rd_en)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                if (!rd_en && !rd_vld_reg)
                begin
                    state_next = S_LAT;
                end
            end

            S_LAT:
            begin
                lat_next   = item_reg.time_now - best_reg.arrival;
                count_next = cnt_m1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand over the result once the response register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    if ((item_reg.action == ACT_POP) && (status_reg == ST_OK))
                    begin
                        if (served_reg != '1)
                        begin
                            served_next = served_reg + 32'd1;
                        end
                        lat_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                    end
                    rsp_next.status       = status_reg;
                    rsp_next.out_tag      = best_reg.tag;
                    rsp_next.out_size     = best_reg.size;
                    rsp_next.latency      = lat_reg;
                    rsp_next.occupancy    = OCC_W'(count_reg);
                    rsp_next.served_total = served_next;
                    rsp_next.latency_sum  = lat_sum_next;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_vld_next = rd_en;
        rd_idx_next = rd_addr;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_STACK;
            count_reg     <= '0;
            served_reg    <= '0;
            lat_sum_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            served_reg    <= served_next;
            lat_sum_reg   <= lat_sum_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_vld_reg    <= rd_vld_next;
            first_reg     <= first_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        item_reg     <= item_next;
        status_reg   <= status_next;
        lat_reg      <= lat_next;
        rsp_reg      <= rsp_next;
        rd_idx_reg   <= rd_idx_next;
    end

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
